FILE: rtl/core/stack_machine_execute_defines.svh
// Assertion macros used by the checker file of the stack machine executor.
`ifndef STACK_MACHINE_EXECUTE_DEFINES_SVH
`define STACK_MACHINE_EXECUTE_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SME_ASSERT_NOW(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define SME_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/sme_pkg.sv
// Types and constants of the stack machine executor.
`timescale 1ns / 1ps
`default_nettype none

package sme_pkg;

  typedef enum logic [4:0] {
    OP_NOP   = 5'd0,
    OP_ADD   = 5'd1,
    OP_SUB   = 5'd2,
    OP_MUL   = 5'd3,
    OP_MOD   = 5'd4,
    OP_LDI   = 5'd5,
    OP_LDS   = 5'd6,
    OP_STS   = 5'd7,
    OP_JUMP  = 5'd8,
    OP_JE    = 5'd9,
    OP_JNE   = 5'd10,
    OP_JLT   = 5'd11,
    OP_CALL  = 5'd12,
    OP_RET   = 5'd13,
    OP_IN    = 5'd14,
    OP_OUT   = 5'd15,
    OP_HALT  = 5'd16,
    OP_ALLOC = 5'd17
  } op_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_DEC,
    S_R1,
    S_R2,
    S_R3,
    S_EXEC,
    S_DIV,
    S_DFIX,
    S_MOVE,
    S_W1,
    S_W2,
    S_DONE
  } state_t;

  localparam logic [1:0] ERR_NONE  = 2'd0;
  localparam logic [1:0] ERR_STACK = 2'd1;
  localparam logic [1:0] ERR_ZMOD  = 2'd2;
  localparam logic [1:0] ERR_BAD   = 2'd3;

  localparam logic [31:0] EMPTY_WORD = 32'hFFFF_FFFF;

endpackage

`default_nettype wire

FILE: rtl/core/stack_machine_execute.sv
// Stack machine executor: runs one instruction per transfer on a memory-held data stack.
`timescale 1ns / 1ps
`default_nettype none

// The block executes one stack machine instruction per input transfer and returns one
// result transfer per instruction, carrying the next program counter, an optional value
// from out or halt, the halt flag and an error code. The data stack sits in one
// synchronous memory with one read and one write port, so the time an instruction takes
// is set by how many stack words it reads and writes: call also moves its arguments, and
// mod runs long because its remainder comes from a bit-serial divider that retires
// one quotient bit per cycle. After reset the block sweeps the stack memory once to fill
// every word with minus one, and no instruction is accepted during the sweep. A finished
// result waits in the output register, and the next instruction is accepted while it
// waits.
module stack_machine_execute #(
  parameter int STACK_DEPTH   = 256,
  parameter int PROGRAM_DEPTH = 4096,
  localparam int PCW          = $clog2(PROGRAM_DEPTH),
  localparam int ODW          = ((PCW + 35 + 7) / 8) * 8
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           s_axis_tvalid,
  output logic                s_axis_tready,
  input  wire logic [31:0]    s_axis_tdata,   // argument [15:0], in_value [31:16]
  input  wire logic [4:0]     s_axis_tuser,   // req_type [4:0]
  output logic                m_axis_tvalid,
  input  wire logic           m_axis_tready,
  output logic [ODW-1:0]      m_axis_tdata,   // next_pc, value, halted, error, zero pad
  output logic                m_axis_tuser    // value_valid
);
  import sme_pkg::*;

  localparam int AW  = $clog2(STACK_DEPTH);
  localparam int SPW = AW + 1;
  localparam int CW  = (SPW > 16 ? SPW : 16) + 3;

  localparam logic signed [CW-1:0] ONE_W   = CW'(1);
  localparam logic signed [CW-1:0] SD_M1   = CW'(STACK_DEPTH - 1);
  localparam logic signed [CW-1:0] SD_M2   = CW'(STACK_DEPTH - 2);
  localparam logic [PCW-1:0]       PC_LAST = PCW'(PROGRAM_DEPTH - 1);
  localparam logic signed [17:0]   PD_S    = 18'(PROGRAM_DEPTH);
  localparam logic signed [32:0]   PD_M2_S = 33'(PROGRAM_DEPTH - 2);
  localparam logic signed [32:0]   NEG1_33 = -33'sd1;
  localparam logic [16:0]          SD_17   = 17'(STACK_DEPTH);
  localparam logic [AW-1:0]        CLR_END = AW'(STACK_DEPTH - 1);

  // Stack memory: one write port, one registered read port.
  logic [31:0] stack_mem [STACK_DEPTH];
  logic        mem_we;
  logic [AW-1:0] mem_wa;
  logic [31:0] mem_wd;
  logic        mem_re;
  logic [AW-1:0] mem_ra;
  logic [31:0] rdata;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      stack_mem[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      rdata <= stack_mem[mem_ra];
    end
  end

  // Architectural state, committed when the result is handed to the output register.
  state_t state, state_next;
  logic signed [SPW-1:0] sp;
  logic [AW-1:0]  fb;
  logic [PCW-1:0] pc;
  logic [AW-1:0]  clr_addr;

  // Latched instruction.
  op_t op;
  logic signed [15:0] arg;
  logic signed [15:0] inv;

  // Words read from the stack, and the writes still to be made.
  logic [31:0]   ra, rb, rc;
  logic [AW-1:0] wa1, wa2;
  logic [31:0]   wd1, wd2;
  logic          need_w2;

  // Pending result and pending state.
  logic [PCW-1:0]        res_pc;
  logic                  res_vv;
  logic [31:0]           res_val;
  logic                  res_halt;
  logic [1:0]            res_err;
  logic signed [SPW-1:0] nsp;
  logic [AW-1:0]         nfb;

  // Argument mover for call.
  logic [AW-1:0] mv_addr;
  logic [AW-1:0] mv_left;

  // Bit-serial remainder unit.
  logic [31:0] dv_rem, dv_dvd, dv_dvs;
  logic [4:0]  dv_cnt;
  logic        dv_neg;
  logic [32:0] dv_trial;
  logic [31:0] dv_rem_next;

  // Index arithmetic on a width that holds every signed intermediate.
  logic signed [CW-1:0] sp_w, fb_w, arg_w, n_w, addr_w, h1_w, spm1_w, spp1_w, h1m1_w;
  logic ok_pop2, ok_pop1, ok_push, addr_ok, call_ok, ret_ok, jmp_ok, n_zero;
  logic [PCW-1:0] pc_inc;

  assign sp_w   = CW'(sp);
  assign fb_w   = CW'($signed({1'b0, fb}));
  assign arg_w  = CW'(arg);
  assign n_w    = arg[15] ? '0 : arg_w;
  assign addr_w = fb_w + arg_w;
  assign spm1_w = sp_w - ONE_W;
  assign spp1_w = sp_w + ONE_W;
  assign h1_w   = spm1_w - arg_w;
  assign h1m1_w = h1_w - ONE_W;
  assign n_zero = (n_w == '0);

  assign ok_pop2 = sp_w >= ONE_W;
  assign ok_pop1 = !sp[SPW-1];
  assign ok_push = sp_w <= SD_M2;
  assign addr_ok = !addr_w[CW-1] && (addr_w <= SD_M1);
  assign call_ok = (sp_w >= n_w) && ok_push;
  assign ret_ok  = ok_pop1 && (h1_w >= ONE_W) && (h1_w <= SD_M1);
  assign jmp_ok  = !arg[15] && (18'(arg) < PD_S);
  assign pc_inc  = (pc == PC_LAST) ? '0 : pc + 1'b1;

  // Checks that need the words read from the stack.
  logic [31:0]        cm1;
  logic signed [17:0] ct;
  logic signed [32:0] cs;
  logic ct_ok, rt_ok, fpv_ok, take_jmp;

  assign cm1    = ra - 32'd1;
  assign ct     = 18'($signed(cm1[15:0])) + 18'sd1;
  assign ct_ok  = !ct[17] && (ct < PD_S);
  assign cs     = 33'($signed(rb));
  assign rt_ok  = (cs >= NEG1_33) && (cs <= PD_M2_S);
  assign fpv_ok = {1'b0, rc[15:0]} < SD_17;
  assign take_jmp = ((op == OP_JE) && (ra == rb)) ||
                    ((op == OP_JNE) && (ra != rb)) ||
                    ((op == OP_JLT) && ($signed(ra) < $signed(rb)));

  assign dv_trial    = {dv_rem, dv_dvd[31]};
  assign dv_rem_next = (dv_trial >= {1'b0, dv_dvs}) ? 32'(dv_trial - {1'b0, dv_dvs})
                                                    : dv_trial[31:0];

  // Error found when decoding, and error found once the operands are in.
  logic [1:0] dec_err, ex_err;
  logic       dec_rd;

  assign s_axis_tready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    mem_we  = 1'b0;
    mem_wa  = sp[AW-1:0];
    mem_wd  = EMPTY_WORD;
    mem_re  = 1'b0;
    mem_ra  = sp[AW-1:0];
    dec_err = ERR_NONE;
    dec_rd  = 1'b0;
    ex_err  = ERR_NONE;

    case (op)
      OP_MOD:  ex_err = (rb == '0) ? ERR_ZMOD : ERR_NONE;
      OP_JE, OP_JNE, OP_JLT: ex_err = (take_jmp && !jmp_ok) ? ERR_BAD : ERR_NONE;
      OP_CALL: ex_err = ct_ok ? ERR_NONE : ERR_BAD;
      OP_RET:  ex_err = !fpv_ok ? ERR_STACK : (!rt_ok ? ERR_BAD : ERR_NONE);
      default: ex_err = ERR_NONE;
    endcase

    case (state)
      S_CLEAR: begin
        mem_we = 1'b1;
        mem_wa = clr_addr;
        if (clr_addr == CLR_END) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (s_axis_tvalid) begin
          state_next = S_DEC;
        end
      end
      S_DEC: begin
        case (op)
          OP_NOP: dec_err = ERR_NONE;
          OP_ADD, OP_SUB, OP_MUL, OP_MOD, OP_JE, OP_JNE, OP_JLT: begin
            if (!ok_pop2) dec_err = ERR_STACK;
            else dec_rd = 1'b1;
          end
          OP_LDI, OP_IN: begin
            if (!ok_push) begin
              dec_err = ERR_STACK;
            end else begin
              mem_we = 1'b1;
              mem_wa = spp1_w[AW-1:0];
              mem_wd = (op == OP_LDI) ? 32'(arg) : 32'(inv);
            end
          end
          OP_LDS: begin
            if (!(addr_ok && ok_push)) begin
              dec_err = ERR_STACK;
            end else begin
              dec_rd = 1'b1;
              mem_ra = addr_w[AW-1:0];
            end
          end
          OP_STS: begin
            if (!(addr_ok && ok_pop1)) dec_err = ERR_STACK;
            else dec_rd = 1'b1;
          end
          OP_JUMP: dec_err = jmp_ok ? ERR_NONE : ERR_BAD;
          OP_CALL: begin
            if (!call_ok) dec_err = ERR_STACK;
            else dec_rd = 1'b1;
          end
          OP_RET: begin
            if (!ret_ok) dec_err = ERR_STACK;
            else dec_rd = 1'b1;
          end
          OP_OUT, OP_HALT: begin
            if (!ok_pop1) dec_err = ERR_STACK;
            else dec_rd = 1'b1;
          end
          OP_ALLOC: dec_err = ok_push ? ERR_NONE : ERR_STACK;
          default: dec_err = ERR_BAD;
        endcase
        mem_re = dec_rd;
        state_next = dec_rd ? S_R1 : S_DONE;
      end
      S_R1: begin
        if (op inside {OP_ADD, OP_SUB, OP_MUL, OP_MOD, OP_JE, OP_JNE, OP_JLT}) begin
          mem_re = 1'b1;
          mem_ra = spm1_w[AW-1:0];
          state_next = S_R2;
        end else if (op == OP_RET) begin
          mem_re = 1'b1;
          mem_ra = h1_w[AW-1:0];
          state_next = S_R2;
        end else begin
          state_next = S_EXEC;
        end
      end
      S_R2: begin
        if (op == OP_RET) begin
          mem_re = 1'b1;
          mem_ra = h1m1_w[AW-1:0];
          state_next = S_R3;
        end else begin
          state_next = S_EXEC;
        end
      end
      S_R3: state_next = S_EXEC;
      S_EXEC: begin
        if (ex_err != ERR_NONE) begin
          state_next = S_DONE;
        end else begin
          case (op)
            OP_ADD, OP_SUB, OP_MUL, OP_STS, OP_JE, OP_JNE, OP_JLT, OP_RET: begin
              mem_we = 1'b1;
              state_next = S_W1;
            end
            OP_MOD: begin
              mem_we = 1'b1;
              state_next = S_DIV;
            end
            OP_OUT, OP_HALT: begin
              mem_we = 1'b1;
              state_next = S_DONE;
            end
            OP_LDS: begin
              mem_we = 1'b1;
              mem_wa = spp1_w[AW-1:0];
              mem_wd = ra;
              state_next = S_DONE;
            end
            OP_CALL: begin
              if (n_zero) begin
                state_next = S_W1;
              end else begin
                mem_re = 1'b1;
                mem_ra = spm1_w[AW-1:0];
                state_next = S_MOVE;
              end
            end
            default: state_next = S_DONE;
          endcase
        end
      end
      S_MOVE: begin
        // Arguments slide up by two, topmost first, one word per cycle.
        mem_we = 1'b1;
        mem_wa = mv_addr + AW'(2);
        mem_wd = rdata;
        if (mv_left != '0) begin
          mem_re = 1'b1;
          mem_ra = mv_addr - 1'b1;
        end else begin
          state_next = S_W1;
        end
      end
      S_DIV: begin
        if (dv_cnt == 5'd31) begin
          state_next = S_DFIX;
        end
      end
      S_DFIX: state_next = S_W1;
      S_W1: begin
        mem_we = 1'b1;
        mem_wa = wa1;
        mem_wd = wd1;
        state_next = need_w2 ? S_W2 : S_DONE;
      end
      S_W2: begin
        mem_we = 1'b1;
        mem_wa = wa2;
        mem_wd = wd2;
        state_next = S_DONE;
      end
      S_DONE: begin
        if (!m_axis_tvalid || m_axis_tready) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_CLEAR;
      clr_addr      <= '0;
      sp            <= '1;
      fb            <= '0;
      pc            <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_CLEAR) begin
        clr_addr <= clr_addr + 1'b1;
      end
      if ((state == S_DONE) && (!m_axis_tvalid || m_axis_tready)) begin
        m_axis_tvalid <= 1'b1;
        sp            <= nsp;
        fb            <= nfb;
        pc            <= res_pc;
      end else if (m_axis_tvalid && m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        op  <= op_t'(s_axis_tuser);
        arg <= $signed(s_axis_tdata[15:0]);
        inv <= $signed(s_axis_tdata[31:16]);
      end
      S_DEC: begin
        res_err  <= dec_err;
        res_vv   <= 1'b0;
        res_val  <= '0;
        res_halt <= (op == OP_HALT);
        need_w2  <= 1'b0;
        nfb      <= fb;
        if (op == OP_HALT) begin
          res_pc <= pc;
        end else if ((op == OP_JUMP) && jmp_ok) begin
          res_pc <= arg[PCW-1:0];
        end else begin
          res_pc <= pc_inc;
        end
        if ((op inside {OP_LDI, OP_IN, OP_ALLOC}) && ok_push) begin
          nsp <= spp1_w[SPW-1:0];
        end else begin
          nsp <= sp;
        end
      end
      S_R1: ra <= rdata;
      S_R2: rb <= rdata;
      S_R3: rc <= rdata;
      S_EXEC: begin
        res_err <= ex_err;
        if (ex_err == ERR_NONE) begin
          case (op)
            OP_ADD, OP_SUB, OP_MUL: begin
              wa1 <= spm1_w[AW-1:0];
              nsp <= spm1_w[SPW-1:0];
              if (op == OP_ADD) wd1 <= ra + rb;
              else if (op == OP_SUB) wd1 <= ra - rb;
              else wd1 <= ra * rb;
            end
            OP_MOD: begin
              wa1    <= spm1_w[AW-1:0];
              nsp    <= spm1_w[SPW-1:0];
              dv_neg <= ra[31];
              dv_dvd <= ra[31] ? -ra : ra;
              dv_dvs <= rb[31] ? -rb : rb;
              dv_rem <= '0;
              dv_cnt <= '0;
            end
            OP_LDS: nsp <= spp1_w[SPW-1:0];
            OP_STS: begin
              wa1 <= addr_w[AW-1:0];
              wd1 <= ra;
              nsp <= spm1_w[SPW-1:0];
            end
            OP_JE, OP_JNE, OP_JLT: begin
              wa1 <= spm1_w[AW-1:0];
              wd1 <= EMPTY_WORD;
              nsp <= SPW'(sp_w - CW'(2));
              if (take_jmp) begin
                res_pc <= arg[PCW-1:0];
              end
            end
            OP_CALL: begin
              // Saved frame base and return counter land below the arguments.
              wa1     <= AW'(sp_w - n_w);
              wd1     <= 32'(fb);
              wa2     <= AW'(sp_w - n_w + ONE_W);
              wd2     <= 32'(pc);
              need_w2 <= 1'b1;
              nsp     <= spp1_w[SPW-1:0];
              nfb     <= spp1_w[AW-1:0];
              res_pc  <= ct[PCW-1:0];
              mv_addr <= spm1_w[AW-1:0];
              mv_left <= AW'(n_w - ONE_W);
            end
            OP_RET: begin
              wa1     <= h1_w[AW-1:0];
              wd1     <= EMPTY_WORD;
              wa2     <= h1m1_w[AW-1:0];
              wd2     <= 32'($signed(ra[15:0]));
              need_w2 <= 1'b1;
              nsp     <= h1m1_w[SPW-1:0];
              nfb     <= rc[AW-1:0];
              res_pc  <= rb[PCW-1:0] + 1'b1;
            end
            OP_OUT, OP_HALT: begin
              res_vv  <= 1'b1;
              res_val <= ra;
              nsp     <= spm1_w[SPW-1:0];
            end
            default: res_vv <= 1'b0;
          endcase
        end
      end
      S_MOVE: begin
        if (mv_left != '0) begin
          mv_addr <= mv_addr - 1'b1;
          mv_left <= mv_left - 1'b1;
        end
      end
      S_DIV: begin
        dv_rem <= dv_rem_next;
        dv_dvd <= {dv_dvd[30:0], 1'b0};
        dv_cnt <= dv_cnt + 1'b1;
      end
      S_DFIX: wd1 <= dv_neg ? -dv_rem : dv_rem;
      S_DONE: begin
        if (!m_axis_tvalid || m_axis_tready) begin
          m_axis_tdata <= ODW'({res_err, res_halt, res_val, res_pc});
          m_axis_tuser <= res_vv;
        end
      end
      default: need_w2 <= need_w2;
    endcase
  end

endmodule

`default_nettype wire

FILE: rtl/core/sme_checker.sv
// Port-level checker of the stack machine executor and its bind.
`timescale 1ns / 1ps
`default_nettype none
`include "stack_machine_execute_defines.svh"

module sme_checker #(
  parameter int PROGRAM_DEPTH = 4096,
  localparam int PCW          = $clog2(PROGRAM_DEPTH),
  localparam int ODW          = ((PCW + 35 + 7) / 8) * 8
) (
  input wire logic           clk,
  input wire logic           rst,
  input wire logic           s_axis_tvalid,
  input wire logic           s_axis_tready,
  input wire logic           m_axis_tvalid,
  input wire logic           m_axis_tready,
  input wire logic [ODW-1:0] m_axis_tdata,
  input wire logic           m_axis_tuser
);
  import sme_pkg::*;

  logic [1:0] err_f;
  logic       halt_f;

  assign err_f  = m_axis_tdata[PCW+34:PCW+33];
  assign halt_f = m_axis_tdata[PCW+32];

  `SME_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "result changed while stalled")
  `SME_ASSERT_NOW(a_value_clean, m_axis_tvalid && m_axis_tuser, err_f == ERR_NONE, "value reported with an error")
  `SME_ASSERT_NOW(a_halt_code, m_axis_tvalid && halt_f, (err_f == ERR_NONE && m_axis_tuser) || (err_f == ERR_STACK && !m_axis_tuser), "halt result inconsistent")
  `SME_ASSERT_NEXT(a_one_item, s_axis_tvalid && s_axis_tready, !s_axis_tready, "second instruction taken back to back")

endmodule

bind stack_machine_execute sme_checker #(.PROGRAM_DEPTH(PROGRAM_DEPTH)) u_sme_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire

FILE: dv/stack_machine_execute_tb.sv
// Self-checking testbench for the stack machine executor.
`timescale 1ns / 1ps

module stack_machine_execute_tb;
  import sme_pkg::*;

  localparam int DEPTH     = 256;
  localparam int PROG      = 4096;
  localparam int WATCHDOG  = 20000;
  localparam int HOLD_LEN  = 400;

  typedef struct {
    logic [4:0]  op;
    logic [15:0] arg;
    logic [15:0] inv;
  } instr_t;

  typedef struct {
    logic [11:0] pc;
    logic        vv;
    logic [31:0] val;
    logic        halted;
    logic [1:0]  err;
  } outcome_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;   // argument [15:0], in_value [31:16]
  logic [4:0]  s_axis_tuser = '0;   // req_type [4:0]
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [47:0] m_axis_tdata;        // next_pc, value, halted, error, zero pad
  logic        m_axis_tuser;        // value_valid

  stack_machine_execute dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow machine state, updated once per accepted instruction.
  logic [31:0] stack_mem [DEPTH];
  int          stack_height;
  logic [31:0] frame_ptr;
  logic [11:0] prog_ctr;

  instr_t   pending_instrs [$];
  outcome_t expected_results [$];
  instr_t   current_instr;

  int total_instrs;
  int instrs_sent = 0;
  int results_checked = 0;
  int mismatches = 0;
  int halts_seen = 0;
  int errors_seen = 0;
  int idle_cycles = 0;
  int hold_count = 0;
  bit hold_done = 1'b0;

  function automatic int phase_of();
    return (total_instrs == 0) ? 0 : (instrs_sent * 5) / total_instrs;
  endfunction

  function automatic bit stack_fits(int pops, int pushes);
    int low;
    low = stack_height - pops;
    return low >= -1 && low + pushes <= DEPTH - 1;
  endfunction

  function automatic logic [31:0] pop_word();
    logic [31:0] v;
    v = stack_mem[stack_height];
    stack_mem[stack_height] = EMPTY_WORD;
    stack_height--;
    return v;
  endfunction

  // Executes one instruction on the shadow state and queues the outcome it must produce.
  task automatic execute_instr(instr_t it);
    outcome_t   res;
    int         argi, addr, n, h0, h1, i;
    longint     nxt, tgt;
    logic [31:0] a, b, r, d, fpv;
    bit         jmp;
    argi = int'($signed(it.arg));
    res = '{pc: 0, vv: 0, val: 0, halted: 0, err: ERR_NONE};
    nxt = (prog_ctr == PROG - 1) ? 0 : prog_ctr + 1;
    case (it.op)
      OP_NOP: ;
      OP_ADD, OP_SUB, OP_MUL, OP_MOD: begin
        if (!stack_fits(2, 1)) res.err = ERR_STACK;
        else begin
          a = stack_mem[stack_height];
          b = stack_mem[stack_height - 1];
          if (it.op == OP_ADD) r = a + b;
          else if (it.op == OP_SUB) r = a - b;
          else if (it.op == OP_MUL) r = a * b;
          else if (b == 0) res.err = ERR_ZMOD;
          else if (a == 32'h8000_0000 && b == 32'hFFFF_FFFF) r = 0;
          else r = $signed(a) % $signed(b);
          if (res.err == ERR_NONE) begin
            stack_mem[stack_height] = EMPTY_WORD;
            stack_height--;
            stack_mem[stack_height] = r;
          end
        end
      end
      OP_LDI, OP_IN: begin
        if (!stack_fits(0, 1)) res.err = ERR_STACK;
        else begin
          stack_height++;
          stack_mem[stack_height] = 32'($signed(it.op == OP_LDI ? it.arg : it.inv));
        end
      end
      OP_LDS, OP_STS: begin
        addr = int'(frame_ptr) + argi;
        if (addr < 0 || addr >= DEPTH ||
            !(it.op == OP_LDS ? stack_fits(0, 1) : stack_fits(1, 0))) res.err = ERR_STACK;
        else if (it.op == OP_LDS) begin
          r = stack_mem[addr];
          stack_height++;
          stack_mem[stack_height] = r;
        end else begin
          r = pop_word();
          stack_mem[addr] = r;
        end
      end
      OP_JUMP: begin
        if (argi < 0 || argi >= PROG) res.err = ERR_BAD;
        else nxt = argi;
      end
      OP_JE, OP_JNE, OP_JLT: begin
        if (!stack_fits(2, 0)) res.err = ERR_STACK;
        else begin
          a = stack_mem[stack_height];
          b = stack_mem[stack_height - 1];
          if (it.op == OP_JE) jmp = (a == b);
          else if (it.op == OP_JNE) jmp = (a != b);
          else jmp = $signed(a) < $signed(b);
          if (jmp && (argi < 0 || argi >= PROG)) res.err = ERR_BAD;
          else begin
            void'(pop_word());
            void'(pop_word());
            if (jmp) nxt = argi;
          end
        end
      end
      OP_CALL: begin
        n = (argi < 0) ? 0 : argi;
        if (stack_height < n || stack_height + 1 > DEPTH - 1) res.err = ERR_STACK;
        else begin
          d = stack_mem[stack_height] - 1;
          tgt = longint'($signed(d[15:0])) + 1;
          if (tgt < 0 || tgt >= PROG) res.err = ERR_BAD;
          else begin
            // Arguments slide up by two slots; copy from the top down since they overlap.
            h0 = stack_height - 1 - n;
            for (i = n - 1; i >= 0; i--) stack_mem[h0 + 3 + i] = stack_mem[h0 + 1 + i];
            stack_mem[h0 + 1] = frame_ptr;
            stack_mem[h0 + 2] = 32'(prog_ctr);
            stack_height++;
            frame_ptr = 32'(stack_height);
            nxt = tgt;
          end
        end
      end
      OP_RET: begin
        h1 = stack_height - 1 - argi;
        if (stack_height < 0 || h1 < 1 || h1 > DEPTH - 1) res.err = ERR_STACK;
        else begin
          fpv = stack_mem[h1 - 1] & 32'hFFFF;
          tgt = longint'($signed(stack_mem[h1])) + 1;
          if (fpv >= DEPTH) res.err = ERR_STACK;
          else if (tgt < 0 || tgt >= PROG) res.err = ERR_BAD;
          else begin
            r = 32'($signed(stack_mem[stack_height][15:0]));
            stack_mem[stack_height] = EMPTY_WORD;
            stack_mem[h1] = EMPTY_WORD;
            stack_mem[h1 - 1] = r;
            stack_height = h1 - 1;
            frame_ptr = fpv;
            nxt = tgt;
          end
        end
      end
      OP_OUT, OP_HALT: begin
        if (it.op == OP_HALT) begin
          res.halted = 1'b1;
          nxt = prog_ctr;
        end
        if (!stack_fits(1, 0)) res.err = ERR_STACK;
        else begin
          res.val = pop_word();
          res.vv = 1'b1;
        end
      end
      OP_ALLOC: begin
        if (!stack_fits(0, 1)) res.err = ERR_STACK;
        else stack_height++;
      end
      default: res.err = ERR_BAD;
    endcase
    prog_ctr = 12'(nxt);
    res.pc = prog_ctr;
    expected_results = {expected_results, res};
  endtask

  task automatic queue_instr(logic [4:0] op, int arg, int inv);
    instr_t it;
    it.op = op;
    it.arg = 16'(arg);
    it.inv = 16'(inv);
    pending_instrs = {pending_instrs, it};
  endtask

  function automatic int rand_value();
    return ($urandom_range(0, 3) == 0) ? int'($urandom_range(0, 65535)) - 32768
                                       : int'($urandom_range(0, 20)) - 10;
  endfunction

  // Fills the instruction queue: directed corner cases first, then random programs.
  task automatic build_stimulus();
    int i, k, n, sel;
    queue_instr(OP_NOP, 0, 0);
    queue_instr(OP_HALT, 0, 0);           // halt with nothing on the stack
    queue_instr(OP_OUT, 0, 0);            // pop from an empty stack
    queue_instr(OP_LDI, 32767, 0);
    queue_instr(OP_IN, 0, -32768);
    queue_instr(OP_ADD, 0, 0);
    queue_instr(OP_LDI, 0, 0);
    queue_instr(OP_MOD, 0, 0);            // zero dividend, minus one as modulus
    queue_instr(OP_LDI, -1, 0);
    queue_instr(OP_LDI, -32768, 0);
    queue_instr(OP_LDI, -32768, 0);
    queue_instr(OP_MUL, 0, 0);
    queue_instr(OP_LDI, 2, 0);
    queue_instr(OP_MUL, 0, 0);            // top is now the most negative word
    queue_instr(OP_MOD, 0, 0);            // most negative mod minus one gives zero
    queue_instr(OP_LDS, -1, 0);           // frame address below the stack
    queue_instr(OP_STS, 300, 0);
    queue_instr(OP_JUMP, 32767, 0);       // target beyond program memory
    queue_instr(OP_JUMP, 4095, 0);
    queue_instr(OP_NOP, 0, 0);            // counter wraps to zero
    queue_instr(5'd18, 0, 0);
    queue_instr(5'd31, -1, 32767);
    queue_instr(OP_LDI, 7, 0);
    queue_instr(OP_LDI, 100, 0);
    queue_instr(OP_CALL, 1, 0);
    queue_instr(OP_RET, 0, 0);
    while (pending_instrs.size() < 1150) begin
      sel = $urandom_range(0, 99);
      if (pending_instrs.size() > 500 && pending_instrs.size() < 520) begin
        // Run the stack into its ceiling, then drain part of it.
        for (i = 0; i < 260; i++) queue_instr(OP_ALLOC, 0, 0);
        for (i = 0; i < 20; i++) queue_instr(OP_OUT, 0, 0);
        for (i = 0; i < 3; i++) queue_instr(OP_RET, $urandom_range(0, 4), 0);
      end else if (sel < 14) begin
        // Call with up to three arguments, a short body and a return; counts are sometimes random.
        n = $urandom_range(0, 3);
        for (k = 0; k < n; k++) queue_instr(OP_LDI, rand_value(), 0);
        queue_instr(OP_LDI, $urandom_range(0, 4095), 0);
        queue_instr(OP_CALL, ($urandom_range(0, 9) == 0) ? rand_value() : n, 0);
        for (k = 0; k < $urandom_range(1, 3); k++)
          queue_instr(($urandom_range(0, 1) != 0) ? OP_LDS : OP_IN,
                      int'($urandom_range(0, 6)) - 4, rand_value());
        queue_instr(OP_RET, ($urandom_range(0, 4) == 0) ? rand_value() : 0, 0);
      end else if (sel < 20) begin
        queue_instr(5'($urandom_range(0, 31)), $urandom_range(0, 65535),
                    $urandom_range(0, 65535));
      end else if (sel < 42) begin
        queue_instr(($urandom_range(0, 1) != 0) ? OP_LDI : OP_IN, rand_value(), rand_value());
      end else if (sel < 57) begin
        queue_instr(5'($urandom_range(OP_ADD, OP_MOD)), 0, 0);
      end else if (sel < 67) begin
        queue_instr(($urandom_range(0, 1) != 0) ? OP_LDS : OP_STS,
                    int'($urandom_range(0, 12)) - 4, 0);
      end else if (sel < 77) begin
        queue_instr(5'($urandom_range(OP_JE, OP_JLT)),
                    ($urandom_range(0, 4) == 0) ? rand_value() : $urandom_range(0, 4095), 0);
      end else if (sel < 88) begin
        queue_instr(($urandom_range(0, 5) == 0) ? OP_HALT : OP_OUT, 0, 0);
      end else begin
        queue_instr(5'($urandom_range(0, 2) == 0 ? OP_ALLOC :
                       $urandom_range(0, 1) == 0 ? OP_NOP : OP_JUMP),
                    $urandom_range(0, 4095), 0);
      end
    end
  endtask

  initial begin
    int i;
    for (i = 0; i < DEPTH; i++) stack_mem[i] = EMPTY_WORD;
    stack_height = -1;
    frame_ptr = 0;
    prog_ctr = 0;
    build_stimulus();
    total_instrs = pending_instrs.size();
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    wait (pending_instrs.size() == 0 && !s_axis_tvalid && expected_results.size() == 0);
    repeat (100) @(posedge clk);
    $display("Ran %0d instructions, checked %0d results: %0d halts, %0d error outcomes.",
             instrs_sent, results_checked, halts_seen, errors_seen);
    $display("Covered call/return frames, stack overflow and underflow, modulus corners.");
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Driver: presents the next queued instruction; predicts each one as it transfers.
  always @(posedge clk) begin : driver
    bit sender_idle;
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        execute_instr(current_instr);
        instrs_sent++;
      end
      case (phase_of())
        1: sender_idle = $urandom_range(0, 99) < 78;
        3: sender_idle = $urandom_range(0, 99) < 21;
        default: sender_idle = 1'b0;
      endcase
      if (!s_axis_tvalid || s_axis_tready) begin
        if (pending_instrs.size() > 0 && !sender_idle) begin
          current_instr = pending_instrs.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata <= {current_instr.inv, current_instr.arg};
          s_axis_tuser <= current_instr.op;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Result side backpressure, with one long hold-off in the last phase.
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else if (hold_count > 0) begin
      hold_count <= hold_count - 1;
      m_axis_tready <= 1'b0;
    end else if (phase_of() == 4 && !hold_done) begin
      hold_done <= 1'b1;
      hold_count <= HOLD_LEN;
      m_axis_tready <= 1'b0;
    end else begin
      case (phase_of())
        2: m_axis_tready <= $urandom_range(0, 99) >= 78;
        3: m_axis_tready <= $urandom_range(0, 99) >= 21;
        default: m_axis_tready <= 1'b1;
      endcase
    end
  end

  // Monitor: checks every result transfer against the oldest expected outcome.
  always @(posedge clk) begin : monitor
    outcome_t exp_res;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result transfer tdata=%h tuser=%b",
                 $realtime, m_axis_tdata, m_axis_tuser);
        mismatches++;
      end else begin
        exp_res = expected_results.pop_front();
        results_checked++;
        if (exp_res.halted) halts_seen++;
        if (exp_res.err != ERR_NONE) errors_seen++;
        if (m_axis_tdata[11:0] !== exp_res.pc) begin
          $display("%0t: next_pc expected %0d actual %0d", $realtime, exp_res.pc,
                   m_axis_tdata[11:0]);
          mismatches++;
        end
        if (m_axis_tuser !== exp_res.vv) begin
          $display("%0t: value_valid expected %b actual %b", $realtime, exp_res.vv,
                   m_axis_tuser);
          mismatches++;
        end
        if (m_axis_tdata[43:12] !== exp_res.val) begin
          $display("%0t: value expected %h actual %h", $realtime, exp_res.val,
                   m_axis_tdata[43:12]);
          mismatches++;
        end
        if (m_axis_tdata[44] !== exp_res.halted) begin
          $display("%0t: halted expected %b actual %b", $realtime, exp_res.halted,
                   m_axis_tdata[44]);
          mismatches++;
        end
        if (m_axis_tdata[46:45] !== exp_res.err) begin
          $display("%0t: error expected %0d actual %0d", $realtime, exp_res.err,
                   m_axis_tdata[46:45]);
          mismatches++;
        end
      end
    end
  end

  // Watchdog: ends the run when no transfer happens on either side for too long.
  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG) begin
      $display("%0t: no transfer for %0d cycles", $realtime, WATCHDOG);
      $display("Regression FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule

FILE: filelist.f
+incdir+rtl/core
rtl/core/sme_pkg.sv
rtl/core/stack_machine_execute.sv
rtl/core/sme_checker.sv
dv/stack_machine_execute_tb.sv
